>>> rtl/core/slpi_pkg.sv
package slpi_pkg;

  localparam int VEC_W     = 25;
  localparam int LEN_W     = 25;
  localparam int COS_W     = 19;
  localparam int DOT_W     = 42;
  localparam int SUMSQ_W   = 50;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT_DIR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEC_EXP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_CUTOFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COLOR   = 3'd6;

  localparam logic [14:0] ONE_Q14          = 15'd16384;
  localparam logic [8:0]  FADE_Q14         = 9'd262;
  // ceil(2^32 / 262): exact floor division for products below 2^28
  localparam logic [23:0] FADE_RECIP       = 24'd16393005;
  localparam int          FADE_RECIP_SHIFT = 32;
  localparam logic [15:0] EXP_ONE          = 16'd256;
  localparam logic [19:0] LOG_BIAS         = 20'd917504; // 14.0 in Q16
  localparam int          EXP_STEPS        = 16;
  localparam int          ROOT_W           = 31;
  localparam int          ROOT_IN_W        = 62;

  typedef enum logic [1:0] {
    MODE_ONE,
    MODE_BASE,
    MODE_ZERO,
    MODE_POW
  } mode_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t                    vec;
    logic signed [DOT_W-1:0] dot;
  } len_tag_t;

  typedef struct packed {
    vec_t             vec;
    logic [LEN_W-1:0] len;
  } div_tag_t;

  typedef struct packed {
    vec_t             vec;
    logic [LEN_W-1:0] len;
    logic             dark;
    mode_t            mode;
    logic [14:0]      t;
    logic             fade;
    logic [8:0]       fade_k;
  } pix_t;

  typedef struct packed {
    pix_t        pix;
    logic [15:0] fp;
    logic [3:0]  ipp;
    logic        pow_zero;
  } pow_tag_t;

  function automatic logic [VEC_W-1:0] sat25(input logic [VEC_W:0] v);
    logic [VEC_W-1:0] r;
    case (v[VEC_W:VEC_W-1])
      2'b01: r = {1'b0, {(VEC_W-1){1'b1}}};
      2'b10: r = {1'b1, {(VEC_W-1){1'b0}}};
      default: r = v[VEC_W-1:0];
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/slpi_sqrt_pipe.sv
module slpi_sqrt_pipe import slpi_pkg::*; #(
  parameter int N_W   = 50,
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [N_W-1:0]       in_n,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [N_W/2-1:0]     out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int STEPS = N_W / 2;

  logic [N_W-1:0]   rem_q [STEPS];
  logic [N_W-1:0]   res_q [STEPS];
  logic [TAG_W-1:0] tag_q [STEPS];
  logic             vld_q [STEPS];

  // one result bit per stage, trial bit walks down by powers of four
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [N_W-1:0] BIT = {{(N_W-1){1'b0}}, 1'b1} << (N_W - 2 - 2 * i);
    logic [N_W-1:0]   rem_in, res_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in;
    logic [N_W:0]     trial;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = in_n;
      assign res_in = '0;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign res_in = res_q[i-1];
      assign tag_in = tag_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= take ? rem_in - trial[N_W-1:0] : rem_in;
        res_q[i] <= take ? (res_in >> 1) + BIT : res_in >> 1;
        tag_q[i] <= tag_in;
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign out_root  = res_q[STEPS-1][STEPS-1:0];
  assign out_tag   = tag_q[STEPS-1];

endmodule

>>> rtl/core/slpi_div_pipe.sv
module slpi_div_pipe import slpi_pkg::*; #(
  parameter int DIVIDEND_W = 42,
  parameter int DIVISOR_W  = 25,
  parameter int Q_W        = 18,
  parameter int TAG_W      = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DIVIDEND_W-1:0] in_dividend,
  input  logic [DIVISOR_W-1:0]         in_divisor,
  input  logic [TAG_W-1:0]             in_tag,
  output logic                         out_valid,
  output logic signed [Q_W:0]          out_quot,
  output logic [TAG_W-1:0]             out_tag
);

  localparam int RW = (DIVIDEND_W > DIVISOR_W + Q_W) ? DIVIDEND_W : DIVISOR_W + Q_W;

  // sign split
  logic [RW-1:0]        mag_p;
  logic [DIVISOR_W-1:0] dvs_p;
  logic                 neg_p;
  logic [TAG_W-1:0]     tag_p;
  logic                 vld_p;
  logic [DIVIDEND_W-1:0] mag_in;

  assign mag_in = in_dividend[DIVIDEND_W-1] ? -in_dividend : in_dividend;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_p <= RW'(mag_in);
      dvs_p <= in_divisor;
      neg_p <= in_dividend[DIVIDEND_W-1];
      tag_p <= in_tag;
    end
  end

  logic [RW-1:0]        rem_q  [Q_W];
  logic [Q_W-1:0]       quot_q [Q_W];
  logic [DIVISOR_W-1:0] dvs_q  [Q_W];
  logic                 neg_q  [Q_W];
  logic [TAG_W-1:0]     tag_q  [Q_W];
  logic                 vld_q  [Q_W];

  // restoring division, one quotient bit per stage, msb first
  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [RW-1:0]        rem_in, trial;
    logic [Q_W-1:0]       quot_in;
    logic [DIVISOR_W-1:0] dvs_in;
    logic                 neg_in, vld_in, take;
    logic [TAG_W-1:0]     tag_in;

    if (i == 0) begin : g_first
      assign rem_in  = mag_p;
      assign quot_in = '0;
      assign dvs_in  = dvs_p;
      assign neg_in  = neg_p;
      assign tag_in  = tag_p;
      assign vld_in  = vld_p;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign quot_in = quot_q[i-1];
      assign dvs_in  = dvs_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign tag_in  = tag_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign trial = RW'(dvs_in) << (Q_W - 1 - i);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= take ? rem_in - trial : rem_in;
        quot_q[i] <= {quot_in[Q_W-2:0], take};
        dvs_q[i]  <= dvs_in;
        neg_q[i]  <= neg_in;
        tag_q[i]  <= tag_in;
      end
    end
  end

  // restore sign, truncation toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quot <= neg_q[Q_W-1] ? -{1'b0, quot_q[Q_W-1]} : {1'b0, quot_q[Q_W-1]};
      out_tag  <= tag_q[Q_W-1];
    end
  end

endmodule

>>> rtl/core/slpi_log_pipe.sv
module slpi_log_pipe import slpi_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [14:0]      in_t,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [3:0]       out_ip,
  output logic [15:0]      out_frac,
  output logic [TAG_W-1:0] out_tag
);

  // normalize: m = t << (30 - ip), m in [2^30, 2^31)
  logic [3:0]        ip_in;
  logic [4:0]        sh_in;
  logic [ROOT_W-1:0] m_in;

  always_comb begin
    ip_in = '0;
    for (int k = 0; k < 14; k++) begin
      if (in_t[k]) begin
        ip_in = 4'(k);
      end
    end
    sh_in = 5'd30 - {1'b0, ip_in};
    m_in  = {16'b0, in_t} << sh_in;
  end

  logic [ROOT_W-1:0] m_p;
  logic [3:0]        ip_p;
  logic [TAG_W-1:0]  tag_p;
  logic              vld_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_p   <= m_in;
      ip_p  <= ip_in;
      tag_p <= in_tag;
    end
  end

  logic [ROOT_W-1:0] m_q    [EXP_STEPS];
  logic [15:0]       frac_q [EXP_STEPS];
  logic [3:0]        ip_q   [EXP_STEPS];
  logic [TAG_W-1:0]  tag_q  [EXP_STEPS];
  logic              vld_q  [EXP_STEPS];

  // one fraction bit per squaring
  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_sq
    logic [ROOT_W-1:0]     m_in_s;
    logic [15:0]           frac_in;
    logic [3:0]            ip_in_s;
    logic [TAG_W-1:0]      tag_in;
    logic                  vld_in;
    logic [2*ROOT_W-1:0]   sq;
    logic [ROOT_W:0]       mm;

    if (i == 0) begin : g_first
      assign m_in_s  = m_p;
      assign frac_in = '0;
      assign ip_in_s = ip_p;
      assign tag_in  = tag_p;
      assign vld_in  = vld_p;
    end else begin : g_next
      assign m_in_s  = m_q[i-1];
      assign frac_in = frac_q[i-1];
      assign ip_in_s = ip_q[i-1];
      assign tag_in  = tag_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign sq = m_in_s * m_in_s;
    assign mm = sq[2*ROOT_W-1:ROOT_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[i]    <= mm[ROOT_W] ? mm[ROOT_W:1] : mm[ROOT_W-1:0];
        frac_q[i] <= {frac_in[14:0], mm[ROOT_W]};
        ip_q[i]   <= ip_in_s;
        tag_q[i]  <= tag_in;
      end
    end
  end

  assign out_valid = vld_q[EXP_STEPS-1];
  assign out_ip    = ip_q[EXP_STEPS-1];
  assign out_frac  = frac_q[EXP_STEPS-1];
  assign out_tag   = tag_q[EXP_STEPS-1];

endmodule

>>> rtl/core/spot_light_pixel_intensity_top.sv
// Spot light pixel intensity. One pixel transaction (x, y, surface z) in,
// one result transaction out: the light vector (saturated to 25 bits), its
// length (floor square root) and the RGB colour in Q8.8 after the spot cone
// test, the spot exponent, the linear edge fade and the colour multiply.
// Throughput is one pixel per clock while the output is not held. The
// deepest part is the chain of sixteen 31-stage integer square roots that
// evaluates the fractional power; beside it are the 25-stage length root,
// the 20-stage divider and the 17-stage log unit. The whole pipeline
// advances together and freezes when the output is held; in_ready is high
// whenever the output register is empty or being taken. Registers are written through the
// cfg port and must only change while no pixel is in flight.
module spot_light_pixel_intensity_top import slpi_pkg::*; #(
  parameter int PIXEL_COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
  input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
  input  logic signed [20:0]          surface_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VEC_W-1:0]     light_vec_x,
  output logic signed [VEC_W-1:0]     light_vec_y,
  output logic signed [VEC_W-1:0]     light_vec_z,
  output logic [LEN_W-1:0]            light_length,
  output logic [15:0]                 out_red,
  output logic [15:0]                 out_green,
  output logic [15:0]                 out_blue
);

  // ---------------------------------------------------------------- config
  logic [23:0] light_pos_x, light_pos_y, light_pos_z;
  logic [47:0] spot_direction;
  logic [15:0] specular_exponent;
  logic [14:0] cone_cutoff;
  logic [23:0] light_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_pos_x       <= '0;
      light_pos_y       <= '0;
      light_pos_z       <= '0;
      spot_direction    <= '0;
      specular_exponent <= EXP_ONE;
      cone_cutoff       <= '0;
      light_color       <= 24'hFFFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LIGHT_POS_X: light_pos_x       <= cfg_data[23:0];
        REG_LIGHT_POS_Y: light_pos_y       <= cfg_data[23:0];
        REG_LIGHT_POS_Z: light_pos_z       <= cfg_data[23:0];
        REG_SPOT_DIR:    spot_direction    <= cfg_data[47:0];
        REG_SPEC_EXP:    specular_exponent <= cfg_data[15:0];
        REG_CONE_CUTOFF: cone_cutoff       <= cfg_data[14:0];
        REG_LIGHT_COLOR: light_color       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the output is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ------------------------------------------------ stage 1: light vector
  logic [VEC_W:0] raw_x, raw_y, raw_z;
  assign raw_x = {{2{light_pos_x[23]}}, light_pos_x} - (VEC_W+1)'({pixel_x, 8'b0});
  assign raw_y = {{2{light_pos_y[23]}}, light_pos_y} - (VEC_W+1)'({pixel_y, 8'b0});
  assign raw_z = {{2{light_pos_z[23]}}, light_pos_z} - {{5{surface_z[20]}}, surface_z};

  vec_t vec1;
  logic v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1.x <= sat25(raw_x);
      vec1.y <= sat25(raw_y);
      vec1.z <= sat25(raw_z);
    end
  end

  // ------------------------------------ stage 2: squares and dot products
  logic signed [15:0] dir_x, dir_y, dir_z;
  assign dir_x = spot_direction[15:0];
  assign dir_y = spot_direction[31:16];
  assign dir_z = spot_direction[47:32];

  logic signed [2*VEC_W-1:0] sqx_f, sqy_f, sqz_f;
  logic signed [VEC_W+15:0]  dpx_f, dpy_f, dpz_f;
  assign sqx_f = vec1.x * vec1.x;
  assign sqy_f = vec1.y * vec1.y;
  assign sqz_f = vec1.z * vec1.z;
  assign dpx_f = vec1.x * dir_x;
  assign dpy_f = vec1.y * dir_y;
  assign dpz_f = vec1.z * dir_z;

  logic [2*VEC_W-2:0]       sqx2, sqy2, sqz2;
  logic signed [VEC_W+15:0] dpx2, dpy2, dpz2;
  vec_t                     vec2;
  logic                     v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= sqx_f[2*VEC_W-2:0];
      sqy2 <= sqy_f[2*VEC_W-2:0];
      sqz2 <= sqz_f[2*VEC_W-2:0];
      dpx2 <= dpx_f;
      dpy2 <= dpy_f;
      dpz2 <= dpz_f;
      vec2 <= vec1;
    end
  end

  // --------------------------------------------------------- stage 3: sums
  logic [SUMSQ_W-1:0]      sumsq3;
  logic signed [DOT_W-1:0] dot3;
  vec_t                    vec3;
  logic                    v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sumsq3 <= {1'b0, sqx2} + {1'b0, sqy2} + {1'b0, sqz2};
      dot3   <= {dpx2[VEC_W+15], dpx2} + {dpy2[VEC_W+15], dpy2} + {dpz2[VEC_W+15], dpz2};
      vec3   <= vec2;
    end
  end

  // ---------------------------------------------------------- length root
  len_tag_t         lt_in, lt_out;
  logic             v_len;
  logic [LEN_W-1:0] len;

  assign lt_in.vec = vec3;
  assign lt_in.dot = dot3;

  slpi_sqrt_pipe #(
    .N_W   (SUMSQ_W),
    .TAG_W ($bits(len_tag_t))
  ) u_len_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_n      (sumsq3),
    .in_tag    (lt_in),
    .out_valid (v_len),
    .out_root  (len),
    .out_tag   (lt_out)
  );

  // ------------------------------------------------ cosine = dot / length
  div_tag_t                dt_in, dt_out;
  logic                    v_div;
  logic signed [COS_W-1:0] cosv;

  assign dt_in.vec = lt_out.vec;
  assign dt_in.len = len;

  slpi_div_pipe #(
    .DIVIDEND_W (DOT_W),
    .DIVISOR_W  (LEN_W),
    .Q_W        (COS_W - 1),
    .TAG_W      ($bits(div_tag_t))
  ) u_cos_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (v_len),
    .in_dividend (lt_out.dot),
    .in_divisor  (len),
    .in_tag      (dt_in),
    .out_valid   (v_div),
    .out_quot    (cosv),
    .out_tag     (dt_out)
  );

  // ------------------------------------------- stage 4: cone and base
  logic signed [19:0] cos_e, cut_e, tn, diff;
  logic               in_cone;
  pix_t               pix_c, pix4;
  logic               v4;

  always_comb begin
    cos_e   = {cosv[COS_W-1], cosv};
    cut_e   = {{5{cone_cutoff[14]}}, cone_cutoff};
    tn      = -cos_e;
    diff    = cut_e - cos_e;
    in_cone = cos_e <= cut_e;

    pix_c.vec    = dt_out.vec;
    pix_c.len    = dt_out.len;
    pix_c.dark   = (dt_out.len == '0) || !in_cone;
    // base saturated to [0, 1.0]
    if (tn < 20'sd0) begin
      pix_c.t = '0;
    end else if (tn > $signed({5'b0, ONE_Q14})) begin
      pix_c.t = ONE_Q14;
    end else begin
      pix_c.t = tn[14:0];
    end
    if (specular_exponent == '0) begin
      pix_c.mode = MODE_ONE;
    end else if (specular_exponent == EXP_ONE || pix_c.t == ONE_Q14) begin
      pix_c.mode = MODE_BASE;
    end else if (pix_c.t == '0) begin
      pix_c.mode = MODE_ZERO;
    end else begin
      pix_c.mode = MODE_POW;
    end
    pix_c.fade   = cos_e > (cut_e - $signed({11'b0, FADE_Q14}));
    pix_c.fade_k = diff[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix4 <= pix_c;
    end
  end

  // ------------------------------------------------------ log2 of base
  pix_t        pix_log;
  logic        v_log;
  logic [3:0]  log_ip;
  logic [15:0] log_frac;

  slpi_log_pipe #(
    .TAG_W ($bits(pix_t))
  ) u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_t      (pix4.t),
    .in_tag    (pix4),
    .out_valid (v_log),
    .out_ip    (log_ip),
    .out_frac  (log_frac),
    .out_tag   (pix_log)
  );

  // ---------------------------------- stage 5: p = -log2(t) * exponent
  logic [19:0] neg_log;
  logic [35:0] p_full;
  assign neg_log = LOG_BIAS - {log_ip, log_frac};
  assign p_full  = neg_log * specular_exponent;

  logic [27:0] p5;
  pix_t        pix5;
  logic        v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v_log;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5   <= p_full[35:8];
      pix5 <= pix_log;
    end
  end

  // -------------------- 2^-frac: sixteen square roots, fraction lsb first
  logic [ROOT_W-1:0] x_chain [EXP_STEPS+1];
  pow_tag_t          t_chain [EXP_STEPS+1];
  logic              v_chain [EXP_STEPS+1];

  assign x_chain[0]          = {1'b1, {(ROOT_W-1){1'b0}}};
  assign t_chain[0].pix      = pix5;
  assign t_chain[0].fp       = p5[15:0];
  assign t_chain[0].ipp      = p5[19:16];
  assign t_chain[0].pow_zero = p5[27:16] >= 12'd15;
  assign v_chain[0]          = v5;

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_root
    logic [ROOT_IN_W-1:0] n_in;
    // (x << 30) >> b
    assign n_in = t_chain[j].fp[j] ? {2'b0, x_chain[j], 29'b0} : {1'b0, x_chain[j], 30'b0};

    slpi_sqrt_pipe #(
      .N_W   (ROOT_IN_W),
      .TAG_W ($bits(pow_tag_t))
    ) u_root (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_chain[j]),
      .in_n      (n_in),
      .in_tag    (t_chain[j]),
      .out_valid (v_chain[j+1]),
      .out_root  (x_chain[j+1]),
      .out_tag   (t_chain[j+1])
    );
  end

  // ------------------------- stage 7: strength select and fade product
  pow_tag_t          pt;
  logic [4:0]        pow_sh;
  logic [ROOT_W-1:0] pow_full;
  logic [14:0]       s_sel;
  logic [23:0]       fade_prod;

  assign pt = t_chain[EXP_STEPS];

  always_comb begin
    pow_sh   = 5'd16 + {1'b0, pt.ipp};
    pow_full = x_chain[EXP_STEPS] >> pow_sh;
    case (pt.pix.mode)
      MODE_ONE:  s_sel = ONE_Q14;
      MODE_BASE: s_sel = pt.pix.t;
      MODE_ZERO: s_sel = '0;
      MODE_POW:  s_sel = pt.pow_zero ? 15'd0 : pow_full[14:0];
      default:   s_sel = '0;
    endcase
    fade_prod = s_sel * pt.pix.fade_k;
  end

  logic [14:0] s7;
  logic [23:0] prod7;
  pix_t        pix7;
  logic        v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v_chain[EXP_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7    <= s_sel;
      prod7 <= fade_prod;
      pix7  <= pt.pix;
    end
  end

  // ------------------------------ stage 8: fade divide by reciprocal
  logic [47:0] recip_prod;
  assign recip_prod = prod7 * FADE_RECIP;

  logic [14:0] s8, q8;
  pix_t        pix8;
  logic        v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8   <= s7;
      q8   <= recip_prod[FADE_RECIP_SHIFT+14:FADE_RECIP_SHIFT];
      pix8 <= pix7;
    end
  end

  // ------------------------------------ stage 9: clamp, colour, output
  logic [14:0] s_fade, s_fin;
  logic [22:0] r_full, g_full, b_full;

  always_comb begin
    s_fade = pix8.fade ? q8 : s8;
    s_fin  = (s_fade > ONE_Q14) ? ONE_Q14 : s_fade;
    r_full = light_color[23:16] * s_fin;
    g_full = light_color[15:8] * s_fin;
    b_full = light_color[7:0] * s_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      light_vec_x  <= pix8.vec.x;
      light_vec_y  <= pix8.vec.y;
      light_vec_z  <= pix8.vec.z;
      light_length <= pix8.len;
      out_red      <= pix8.dark ? 16'd0 : r_full[21:6];
      out_green    <= pix8.dark ? 16'd0 : g_full[21:6];
      out_blue     <= pix8.dark ? 16'd0 : b_full[21:6];
    end
  end

endmodule

>>> test/testbench.sv
module testbench import slpi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_PIXELS  = 50;

  // one light setting, register by register
  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [47:0]        dir;
    logic [15:0]        spec_exp;
    logic signed [14:0] cutoff;
    logic [23:0]        color;
  } light_cfg_t;

  // one result transaction
  typedef struct {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
    logic [LEN_W-1:0]        len;
    logic [15:0]             red;
    logic [15:0]             green;
    logic [15:0]             blue;
  } shade_t;

  // directed stimulus: group selects the light setting; known marks a typed-in color
  typedef struct {
    int  grp;
    int  px;
    int  py;
    int  pz;
    bit  known;
    int  color;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LIGHT_POS_X;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic signed [20:0] surface_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEC_W-1:0] light_vec_x, light_vec_y, light_vec_z;
  logic [LEN_W-1:0] light_length;
  logic [15:0] out_red, out_green, out_blue;

  light_cfg_t light;       // predictor's copy of the registers
  shade_t     shade_q[$];  // expected results, oldest first
  int         mismatches = 0;
  int         cycles = 0;
  int         burst_left = 0;

  spot_light_pixel_intensity_top #(.PIXEL_COORD_BITS(12)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp25(longint v);
    if (v < -(64'sd1 <<< 24)) return -(64'sd1 <<< 24);
    if (v > (64'sd1 <<< 24) - 1) return (64'sd1 <<< 24) - 1;
    return v;
  endfunction

  // t^e for 0 < t < 1.0 (Q14), e in Q8.8: via log2 and a chain of square roots
  function automatic longint unsigned spot_power(longint unsigned t, longint unsigned e);
    int unsigned ip;
    longint unsigned m, frac, neg, p, fp, ipp, x, b;
    ip = 0;
    frac = 0;
    while (ip < 13 && (t >> (ip + 1)) != 0) ip++;
    m = t << (30 - ip);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    neg = (64'd14 << 16) - ((longint'(ip) << 16) | frac);
    p = (neg * e) >> 8;
    ipp = p >> 16;
    if (ipp >= 15) return 0;
    fp = p & 64'hFFFF;
    x = 64'd1 << 30;
    for (int k = 16; k >= 1; k--) begin
      b = (fp >> (16 - k)) & 1;
      x = root64((x << 30) >> b);
    end
    return x >> (16 + ipp);
  endfunction

  function automatic shade_t shade_pixel(logic [11:0] px, logic [11:0] py,
                                         logic signed [20:0] sz);
    shade_t r;
    longint vx, vy, vz, dot, cosv, cut, tn;
    longint unsigned len, t, s;
    mode_t mode;
    vx = clamp25(longint'(light.pos_x) - (longint'(px) << 8));
    vy = clamp25(longint'(light.pos_y) - (longint'(py) << 8));
    vz = clamp25(longint'(light.pos_z) - longint'(sz));
    len = root64(longint'(vx * vx + vy * vy + vz * vz));
    r.vx = vx[VEC_W-1:0];
    r.vy = vy[VEC_W-1:0];
    r.vz = vz[VEC_W-1:0];
    r.len = len[LEN_W-1:0];
    r.red = '0;
    r.green = '0;
    r.blue = '0;
    if (len == 0) return r;
    dot = vx * longint'($signed(light.dir[15:0])) + vy * longint'($signed(light.dir[31:16]))
        + vz * longint'($signed(light.dir[47:32]));
    cosv = dot / longint'(len);
    cut = longint'(light.cutoff);
    if (cosv > cut) return r;  // outside the cone
    tn = -cosv;
    if (tn < 0) tn = 0;
    if (tn > 16384) tn = 16384;
    t = longint'(tn);
    if (light.spec_exp == 0) mode = MODE_ONE;
    else if (light.spec_exp == EXP_ONE || t == 16384) mode = MODE_BASE;
    else if (t == 0) mode = MODE_ZERO;
    else mode = MODE_POW;
    case (mode)
      MODE_ONE:  s = 16384;
      MODE_BASE: s = t;
      MODE_ZERO: s = 0;
      default:   s = spot_power(t, longint'(light.spec_exp));
    endcase
    if (cosv > cut - 262) s = s * longint'(cut - cosv) / 262;  // edge fade
    if (s > 16384) s = 16384;
    r.red   = 16'((longint'(light.color[23:16]) * s) >> 6);
    r.green = 16'((longint'(light.color[15:8]) * s) >> 6);
    r.blue  = 16'((longint'(light.color[7:0]) * s) >> 6);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  // all writes happen with no pixel in flight; called right after a rising edge
  task automatic load_light(light_cfg_t c);
    logic [CFG_W-1:0] vals[7];
    vals[REG_LIGHT_POS_X] = CFG_W'($unsigned(c.pos_x));
    vals[REG_LIGHT_POS_Y] = CFG_W'($unsigned(c.pos_y));
    vals[REG_LIGHT_POS_Z] = CFG_W'($unsigned(c.pos_z));
    vals[REG_SPOT_DIR]    = c.dir;
    vals[REG_SPEC_EXP]    = CFG_W'(c.spec_exp);
    vals[REG_CONE_CUTOFF] = CFG_W'($unsigned(c.cutoff));
    vals[REG_LIGHT_COLOR] = CFG_W'(c.color);
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    light = c;
  endtask

  // hold off the sender until the pipe has emptied
  task automatic drain_pipe;
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  // one pixel transaction; entered and left just after a rising edge
  task automatic send_pixel(int px, int py, int pz, bit known, int color);
    shade_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    pixel_x   <= 12'(px);
    pixel_y   <= 12'(py);
    surface_z <= 21'(pz);
    // in_ready is stable by the falling edge; the transaction completes on the next rise
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    e = shade_pixel(12'(px), 12'(py), 21'(pz));
    if (known) begin
      e.red = 16'(color);
      e.green = 16'(color);
      e.blue = 16'(color);
    end
    shade_q.push_back(e);
  endtask

  function automatic light_cfg_t random_light(int phase);
    light_cfg_t c;
    longint dx, dy, dz;
    c.pos_x = 24'($urandom_range(0, 4095) << 8);
    c.pos_y = 24'($urandom_range(0, 4095) << 8);
    c.pos_z = 24'($urandom_range(16, 4000) << 8);
    dx = longint'($urandom_range(0, 8000)) - 4000;
    dy = longint'($urandom_range(0, 8000)) - 4000;
    dz = -longint'(root64(longint'(16384 * 16384 - dx * dx - dy * dy)));
    c.dir = {16'(dz), 16'(dy), 16'(dx)};
    case ($urandom_range(0, 5))
      0: c.spec_exp = 16'd0;
      1: c.spec_exp = EXP_ONE;
      2: c.spec_exp = 16'd32768;
      3: c.spec_exp = 16'd1;
      default: c.spec_exp = 16'($urandom_range(2, 4000));
    endcase
    c.cutoff = -15'($urandom_range(0, 16384));
    c.color = 24'($urandom);
    // a couple of phases sit at the register extremes
    if (phase == 0) begin
      c.pos_x = 24'sh7FFFFF;
      c.pos_y = 24'sh800000;
      c.pos_z = 24'sh7FFFFF;
      c.cutoff = 15'sh4000;
      c.color = 24'hFFFFFF;
    end else if (phase == 1) begin
      c.pos_x = 24'($urandom);
      c.pos_y = 24'($urandom);
      c.pos_z = 24'($urandom);
      c.dir = {16'($urandom), 32'($urandom)};
      c.cutoff = '0;
      c.color = 24'h000000;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- receiver

  // three stall regimes in turn: always ready, pseudo-random, periodic
  logic [15:0] stall_lfsr = 16'hACE1;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12]
                   ^ stall_lfsr[10]};
    case ((cycles / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= stall_lfsr[0] | stall_lfsr[3];
      default: out_ready <= (cycles % 7) != 0;
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result check: sampled on the falling edge, completes on the next rise
  always @(negedge clk) begin
    shade_t e;
    if (!rst && out_valid && out_ready) begin
      if (shade_q.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        e = shade_q.pop_front();
        if (light_vec_x !== e.vx) begin
          $error("light_vec_x expected %0d actual %0d", e.vx, light_vec_x);
          mismatches++;
        end
        if (light_vec_y !== e.vy) begin
          $error("light_vec_y expected %0d actual %0d", e.vy, light_vec_y);
          mismatches++;
        end
        if (light_vec_z !== e.vz) begin
          $error("light_vec_z expected %0d actual %0d", e.vz, light_vec_z);
          mismatches++;
        end
        if (light_length !== e.len) begin
          $error("light_length expected %0d actual %0d", e.len, light_length);
          mismatches++;
        end
        if (out_red !== e.red) begin
          $error("out_red expected %0d actual %0d", e.red, out_red);
          mismatches++;
        end
        if (out_green !== e.green) begin
          $error("out_green expected %0d actual %0d", e.green, out_green);
          mismatches++;
        end
        if (out_blue !== e.blue) begin
          $error("out_blue expected %0d actual %0d", e.blue, out_blue);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // directed light settings, one per group of the table
  light_cfg_t preset[9];
  pixel_row_t pixel_rows[20] = '{
    // reset setting: no direction, so every color is dark
    '{0, 0, 0, 0, 1, 0},                 // zero-length vector
    '{0, 4095, 4095, 0, 1, 0},
    '{0, 0, 4095, -1048576, 1, 0},
    '{0, 4095, 0, 1048575, 1, 0},
    '{0, 2730, 1365, 699050, 1, 0},
    '{0, 1365, 2730, -699051, 1, 0},
    // light straight above, exponent 1.0: full white
    '{1, 100, 100, 0, 1, 65280},
    '{1, 90, 120, -2560, 0, 0},
    // exponent zero
    '{2, 100, 100, 0, 1, 65280},
    '{2, 0, 0, 0, 0, 0},
    // fractional power
    '{3, 100, 100, 0, 0, 0},
    '{3, 60, 130, 5000, 0, 0},
    '{3, 300, 40, -9000, 0, 0},
    // narrow cone: far pixel is outside
    '{4, 4095, 0, 0, 1, 0},
    '{4, 101, 99, 0, 0, 0},
    // extreme positions: largest vector components
    '{5, 0, 4095, -1048576, 0, 0},
    // huge exponent on a base just below one
    '{6, 140, 60, 0, 0, 0},
    // direction longer than one: base clamps
    '{7, 100, 100, 0, 0, 0},
    // no direction, nonzero exponent: zero base
    '{8, 100, 100, 0, 0, 0},
    '{8, 7, 4000, 100, 0, 0}
  };

  initial begin
    light_cfg_t c;
    int cur_grp;
    int cx, cy;
    // reset values of the registers
    light = '{24'sd0, 24'sd0, 24'sd0, 48'd0, EXP_ONE, 15'sd0, 24'hFFFFFF};
    preset[0] = light;
    preset[1] = '{24'sd25600, 24'sd25600, 24'sd256000, {-16'sd16384, 32'd0}, EXP_ONE,
                  15'sd0, 24'hFFFFFF};
    preset[2] = preset[1];
    preset[2].spec_exp = 16'd0;
    preset[3] = preset[1];
    preset[3].spec_exp = 16'd384;
    preset[3].color = 24'h80C040;
    preset[4] = preset[1];
    preset[4].cutoff = -15'sd15000;
    preset[5] = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, {-16'sd16384, 32'd0}, EXP_ONE,
                  -15'sd16384, 24'h123456};
    preset[6] = preset[1];
    preset[6].spec_exp = 16'd32768;
    preset[7] = preset[1];
    preset[7].dir = {16'sh8000, 32'd0};
    preset[8] = preset[1];
    preset[8].dir = 48'd0;
    preset[8].spec_exp = 16'd384;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; registers start at their reset values
    cur_grp = 0;
    foreach (pixel_rows[i]) begin
      if (pixel_rows[i].grp != cur_grp) begin
        cur_grp = pixel_rows[i].grp;
        drain_pipe();
        load_light(preset[cur_grp]);
      end
      send_pixel(pixel_rows[i].px, pixel_rows[i].py, pixel_rows[i].pz,
                 pixel_rows[i].known, pixel_rows[i].color);
    end

    // random phases: mostly pixels near the light, the rest anywhere
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_pipe();
      c = random_light(ph);
      load_light(c);
      cx = int'(c.pos_x >>> 8);
      cy = int'(c.pos_y >>> 8);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (ph == 3 && n == PHASE_PIXELS / 2) drain_pipe();  // let the pipe run dry once
        if ($urandom_range(0, 9) < 7 && ph > 1) begin
          send_pixel(cx < 0 ? 0 : (cx + $urandom_range(0, 256) - 128) & 12'hFFF,
                     cy < 0 ? 0 : (cy + $urandom_range(0, 256) - 128) & 12'hFFF,
                     int'($urandom_range(0, 20000)) - 10000, 1'b0, 0);
        end else begin
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                     int'($urandom_range(0, 2097151)) - 1048576, 1'b0, 0);
        end
      end
    end

    drain_pipe();
    repeat (600) @(posedge clk);
    if (mismatches == 0 && shade_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> spot_light_pixel_intensity_top.f
rtl/core/slpi_pkg.sv
rtl/core/slpi_sqrt_pipe.sv
rtl/core/slpi_div_pipe.sv
rtl/core/slpi_log_pipe.sv
rtl/core/spot_light_pixel_intensity_top.sv
test/testbench.sv
